/* sv/assm_pkg.sv */
`timescale 1ns / 1ps
// shared codes and defaults for the array stack search engine
// no dependencies; imported by array_stack_search_minmax_top
package assm_pkg;

    // default number of stored words and reset value of the capacity register
    localparam int          DEPTH_DEFAULT  = 32;
    localparam logic [5:0]  CAPACITY_RESET = 6'd20;

    // operation codes
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_MAX    = 3'd3;
    localparam logic [2:0] OP_MIN    = 3'd4;
    localparam logic [2:0] OP_LIST   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // result kind codes
    localparam logic [2:0] KIND_PUSH_ACK = 3'd0;
    localparam logic [2:0] KIND_POPPED   = 3'd1;
    localparam logic [2:0] KIND_MATCH    = 3'd2;
    localparam logic [2:0] KIND_COUNT    = 3'd3;
    localparam logic [2:0] KIND_MAX      = 3'd4;
    localparam logic [2:0] KIND_MIN      = 3'd5;
    localparam logic [2:0] KIND_ELEMENT  = 3'd6;

    // kind reported alongside an empty status
    function automatic logic [2:0] empty_kind(input logic [2:0] op);
        logic [2:0] k;
        k = KIND_PUSH_ACK;
        unique case (op)
            OP_POP:    k = KIND_POPPED;
            OP_SEARCH: k = KIND_COUNT;
            OP_MAX:    k = KIND_MAX;
            OP_MIN:    k = KIND_MIN;
            OP_LIST:   k = KIND_ELEMENT;
            default:   k = KIND_PUSH_ACK;
        endcase
        return k;
    endfunction

endpackage

/* sv/array_stack_search_minmax_top.sv */
`timescale 1ns / 1ps
// bounded word store with push, pop, search, max, min and list operations
// depends on assm_pkg for operation, status and kind codes

// A stack of signed 32-bit words held in a single-port store of DEPTH entries,
// with a fill count. Commands arrive on the slave stream (op in tuser, word in
// tdata); results leave on the master stream, with the final result of each
// command marked by tlast. Push, and pop/search/max/min/list on an empty store,
// give one result, registered as the command is taken. Pop reads the top word
// and gives one result. Search, max, min and list walk the stored words one per
// cycle through the store's registered read port and one shared compare unit;
// a result that the sink does not take stalls the walk. The slave side is not
// ready while a command is being worked on or while an earlier result still
// waits. Op codes 6 and 7 are taken and give no result. The capacity register
// (written through i_cfg_we / i_cfg_wdata) bounds pushes and saturates at
// DEPTH; it should only be written while the block is idle.
module array_stack_search_minmax_top
    import assm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // capacity register write
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,

    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] op

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] status, [33:2] data, [38:34] position,
                                        // [44:39] tally, [47:45] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // final result of the command
);

    // count width holds 0..DEPTH, address width indexes the store
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    // element store, single port, registered read
    logic [31:0]        r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    // control state
    logic [1:0]     r_state, n_state;
    logic [CW-1:0]  r_fill,  n_fill;
    logic [5:0]     r_cap;
    logic [CW-1:0]  r_idx,   n_idx;     // next index to read
    logic [CW-1:0]  r_pidx,  n_pidx;    // index of the word in r_rdata
    logic           r_pend,  n_pend;    // r_rdata holds a word not yet used
    logic [5:0]     r_hits,  n_hits;
    logic [2:0]     r_op,    n_op;
    logic signed [31:0] r_key,  n_key;
    logic signed [31:0] r_best, n_best;
    logic [CW-1:0]  r_bidx,  n_bidx;

    // output register
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_ostat,  n_ostat;
    logic [2:0]     r_okind,  n_okind;
    logic [31:0]    r_odata,  n_odata;
    logic [4:0]     r_opos,   n_opos;
    logic [5:0]     r_otally, n_otally;
    logic           r_olast,  n_olast;

    logic           w_out_free;
    logic           w_in_acc;
    logic [5:0]     w_bound;
    logic           w_full;
    logic           w_empty;
    logic           w_wr_en;
    logic           w_match;
    logic           w_better;
    logic           w_need_emit;
    logic           w_consume;
    logic           w_lastel;
    logic           w_issue;
    logic [CW+4:0]  w_pidx_ext;
    logic [CW+4:0]  w_fill_ext;
    logic [CW+4:0]  w_bidx_ext;

    // output slot is free when empty or being drained this cycle
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // push bound: capacity saturated at the store depth
    assign w_bound = (r_cap < 6'(DEPTH)) ? r_cap : 6'(DEPTH);
    assign w_full  = 7'(r_fill) >= 7'(w_bound);
    assign w_empty = (r_fill == '0);
    assign w_wr_en = w_in_acc && (s_axis_tuser == OP_PUSH) && !w_full;

    // shared compare unit on the word just read
    assign w_match  = (r_rdata == r_key);
    assign w_better = (r_op == OP_MAX) ? (r_best < r_rdata) : (r_rdata < r_best);

    // only match, list and pop words need a free output slot to move on
    assign w_need_emit = ((r_op == OP_SEARCH) && w_match) ||
                         (r_op == OP_LIST) || (r_op == OP_POP);
    assign w_consume   = r_pend && (!w_need_emit || w_out_free);
    assign w_lastel    = (r_pidx == CW'(r_fill - CW'(1)));
    assign w_issue     = (r_state == S_SCAN) && (r_idx != r_fill) &&
                         (!r_pend || w_consume);

    // positions are reported in five bits
    assign w_pidx_ext = (CW + 5)'(r_pidx);
    assign w_fill_ext = (CW + 5)'(r_fill);
    assign w_bidx_ext = (CW + 5)'(r_bidx);

    // store write on push, read one word per cycle during a walk unless a waiting result holds it
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_fill[AW-1:0]] <= s_axis_tdata;
        end
        if (w_issue) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_hits   = r_hits;
        n_op     = r_op;
        n_key    = r_key;
        n_best   = r_best;
        n_bidx   = r_bidx;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ostat  = r_ostat;
        n_okind  = r_okind;
        n_odata  = r_odata;
        n_opos   = r_opos;
        n_otally = r_otally;
        n_olast  = r_olast;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = s_axis_tuser;
                    n_key  = s_axis_tdata;
                    n_hits = '0;
                    case (s_axis_tuser) inside
                        OP_PUSH: begin
                            n_ovalid = 1'b1;
                            n_okind  = KIND_PUSH_ACK;
                            n_odata  = '0;
                            n_otally = '0;
                            n_olast  = 1'b1;
                            if (w_full) begin
                                n_ostat = ST_FULL;
                                n_opos  = '0;
                            end else begin
                                n_ostat = ST_OK;
                                n_opos  = w_fill_ext[4:0];
                                n_fill  = r_fill + CW'(1);
                            end
                        end
                        OP_POP, OP_SEARCH, OP_MAX, OP_MIN, OP_LIST: begin
                            if (w_empty) begin
                                n_ovalid = 1'b1;
                                n_ostat  = ST_EMPTY;
                                n_okind  = empty_kind(s_axis_tuser);
                                n_odata  = '0;
                                n_opos   = '0;
                                n_otally = '0;
                                n_olast  = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                                n_idx   = (s_axis_tuser == OP_POP) ?
                                          CW'(r_fill - CW'(1)) : '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_issue) begin
                    n_idx  = r_idx + CW'(1);
                    n_pidx = r_idx;
                    n_pend = 1'b1;
                end else if (w_consume) begin
                    n_pend = 1'b0;
                end
                if (w_consume) begin
                    case (r_op)
                        OP_POP: begin
                            n_ovalid = 1'b1;
                            n_ostat  = ST_OK;
                            n_okind  = KIND_POPPED;
                            n_odata  = r_rdata;
                            n_opos   = '0;
                            n_otally = '0;
                            n_olast  = 1'b1;
                            n_fill   = r_fill - CW'(1);
                            n_state  = S_IDLE;
                        end
                        OP_LIST: begin
                            n_ovalid = 1'b1;
                            n_ostat  = ST_OK;
                            n_okind  = KIND_ELEMENT;
                            n_odata  = r_rdata;
                            n_opos   = w_pidx_ext[4:0];
                            n_otally = '0;
                            n_olast  = w_lastel;
                            if (w_lastel) begin
                                n_state = S_IDLE;
                            end
                        end
                        OP_SEARCH: begin
                            if (w_match) begin
                                n_ovalid = 1'b1;
                                n_ostat  = ST_OK;
                                n_okind  = KIND_MATCH;
                                n_odata  = r_key;
                                n_opos   = w_pidx_ext[4:0];
                                n_otally = '0;
                                n_olast  = 1'b0;
                                n_hits   = r_hits + 6'd1;
                            end
                            if (w_lastel) begin
                                n_state = S_FINAL;
                            end
                        end
                        default: begin
                            // max or min: first word seeds, strict compare keeps lowest index
                            if ((r_pidx == '0) || w_better) begin
                                n_best = r_rdata;
                                n_bidx = r_pidx;
                            end
                            if (w_lastel) begin
                                n_state = S_FINAL;
                            end
                        end
                    endcase
                end
            end

            S_FINAL: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = ST_OK;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                    if (r_op == OP_SEARCH) begin
                        n_okind  = KIND_COUNT;
                        n_odata  = r_key;
                        n_opos   = '0;
                        n_otally = r_hits;
                    end else begin
                        n_okind  = (r_op == OP_MAX) ? KIND_MAX : KIND_MIN;
                        n_odata  = r_best;
                        n_opos   = w_bidx_ext[4:0];
                        n_otally = '0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cap    <= CAPACITY_RESET;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_hits   <= n_hits;
        r_op     <= n_op;
        r_key    <= n_key;
        r_best   <= n_best;
        r_bidx   <= n_bidx;
        r_ostat  <= n_ostat;
        r_okind  <= n_okind;
        r_odata  <= n_odata;
        r_opos   <= n_opos;
        r_otally <= n_otally;
        r_olast  <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_otally, r_opos, r_odata, r_ostat};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= DEPTH)
        else $error("fill count beyond depth");

    // a pending read word only exists during a walk
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("read word pending outside a walk");

    // a push that fits grows the fill count by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_fill == CW'($past(r_fill) + CW'(1))))
        else $error("push did not advance fill count");

    // match count never exceeds the number of stored words
    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (7'(r_hits) <= 7'(r_fill)))
        else $error("match count beyond fill count");

endmodule
